// File: hdl/dkrs_pkg.sv
package dkrs_pkg;

	localparam int DEPTH = 64;
	localparam int KEY_W = 9;
	localparam int IDX_W = 6;
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef struct packed {
		logic [4:0] day;
		logic [3:0] month;
		logic       last;
	} item_t;

	typedef struct packed {
		logic [IDX_W-1:0] record_index;
		logic [KEY_W-1:0] sort_key;
		logic             last_out;
	} result_t;

	// one slot of the sorted chain
	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
		logic [IDX_W-1:0] idx;
	} entry_t;

	// broadcast from the top level to every cell
	typedef struct packed {
		logic             load;
		logic             shift;
		logic [KEY_W-1:0] key;
		logic [IDX_W-1:0] idx;
	} cell_ctl_t;

endpackage

// File: hdl/date_key_record_sorter.sv
// Loading: one word per cycle, each record placed in the cell chain on arrival
// while a cell is free. After the word marked last, the chain drains one sorted
// word per cycle from its head cell while result_stall is low; input stalls until
// the final result is taken (first result in the cycle after the last word is accepted).
// Reset (arst_n low) empties the chain and clears the record count.
module date_key_record_sorter (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  dkrs_pkg::item_t     item,
	output logic                result_valid,
	input  logic                result_stall,
	output dkrs_pkg::result_t   result
);
	import dkrs_pkg::*;

	logic             drain_q;
	logic [CNT_W-1:0] count_q;
	logic             item_acc;
	logic             result_acc;
	logic             has_room;
	logic [3:0]       month_m1;
	cell_ctl_t        ctl;
	entry_t           ent   [DEPTH];
	logic             gt    [DEPTH];

	assign item_stall = drain_q;
	assign item_acc   = item_valid && !drain_q;
	assign has_room   = count_q < CNT_W'(DEPTH);

	// form the date key and the insert command
	assign month_m1  = item.month - 4'd1;
	assign ctl.key   = {month_m1, 5'b0} + {4'b0, item.day};
	assign ctl.idx   = count_q[IDX_W-1:0];
	assign ctl.load  = item_acc && has_room;
	assign ctl.shift = result_acc;

	// head cell holds the next result
	assign result_valid          = drain_q && ent[0].valid;
	assign result.record_index   = ent[0].idx;
	assign result.sort_key       = ent[0].key;
	assign result.last_out       = !ent[1].valid;
	assign result_acc            = result_valid && !result_stall;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		entry_t left_e;
		logic   left_g;
		entry_t right_e;

		if (i == 0) begin : g_head
			assign left_e = '0;
			assign left_g = 1'b0;
		end else begin : g_mid
			assign left_e = ent[i-1];
			assign left_g = gt[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign right_e = '0;
		end else begin : g_body
			assign right_e = ent[i+1];
		end

		dkrs_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.left    (left_e),
			.left_gt (left_g),
			.right   (right_e),
			.ent     (ent[i]),
			.gt      (gt[i])
		);
	end

	// count records, enter drain on last, leave after the final word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (item_acc && item.last) begin
				drain_q <= 1'b1;
				count_q <= '0;
			end else if (ctl.load) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (result_acc && result.last_out) begin
				drain_q <= 1'b0;
			end
		end
	end

endmodule

// File: hdl/dkrs_cell.sv
module dkrs_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  dkrs_pkg::cell_ctl_t ctl,
	input  dkrs_pkg::entry_t   left,
	input  logic               left_gt,
	input  dkrs_pkg::entry_t   right,
	output dkrs_pkg::entry_t   ent,
	output logic               gt
);
	import dkrs_pkg::*;

	logic             valid_q;
	logic [KEY_W-1:0] key_q;
	logic [IDX_W-1:0] idx_q;
	entry_t           nxt;

	assign ent = '{valid: valid_q, key: key_q, idx: idx_q};

	// an empty slot counts as larger than any key
	assign gt = !valid_q || (key_q > ctl.key);

	// pick the next slot content: drain left, shift right on insert, take the new record, or hold
	always_comb begin
		nxt = ent;
		if (ctl.shift) begin
			nxt = right;
		end else if (ctl.load) begin
			if (left_gt) begin
				nxt = left;
			end else if (gt) begin
				nxt = '{valid: 1'b1, key: ctl.key, idx: ctl.idx};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		key_q <= nxt.key;
		idx_q <= nxt.idx;
	end

endmodule
